[src/tmt_pkg.sv]
// Shared constants, register indexes and sequencer states for the tick-to-millisecond timer.
package tmt_pkg;

    // Default geometry
    localparam int TMT_COUNTER_BITS    = 64;
    localparam int TMT_CLOCK_BITS      = 32;
    localparam int TMT_SCALE_FRAC_BITS = 12;

    // Fixed field widths
    localparam int TMT_SCALE_W   = 16;
    localparam int TMT_TPM_W     = 32;
    localparam int TMT_IN_W      = 64;
    localparam int TMT_USER_W    = 2;
    localparam int TMT_OUT_W     = 32;
    localparam int TMT_OUT_NUM   = 5;
    localparam int TMT_CFG_W     = 32;
    localparam int TMT_CFG_ADDR_W = 2;

    // Frame step is elapsed milliseconds over this constant
    localparam int TMT_FRAME_DIV = 20;
    // Frame step fraction bits (Q16.16)
    localparam int TMT_STEP_FRAC = 16;

    // Configuration register indexes
    localparam logic [TMT_CFG_ADDR_W-1:0] REG_TIME_SCALE  = 2'd0;
    localparam logic [TMT_CFG_ADDR_W-1:0] REG_TICKS_PER_MS = 2'd1;
    localparam logic [TMT_CFG_ADDR_W-1:0] REG_SCALE_PAUSED = 2'd2;

    // Configuration reset values
    localparam logic [TMT_SCALE_W-1:0] RST_TIME_SCALE   = 16'd4096;
    localparam logic [TMT_TPM_W-1:0]   RST_TICKS_PER_MS = 32'd10000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV_MS,
        ST_FRAME_CHK,
        ST_DIV_FRAME,
        ST_DONE
    } tmt_state_t;

endpackage

[src/tick_to_millisecond_timer.sv]
// Top level of the tick-to-millisecond timer: sequencer, state and stream ports.
//
// Each sample of the free-running tick counter (s_tdata) with its two pause flags
// (s_tuser) produces one result on m_tdata. The block works on one sample at a time.
// A shift-and-add multiply steps through the scale bits (FACT_W, 16 at the default
// geometry). The millisecond division loads the divider, takes one quotient bit per
// bit of the scaled sum (SUM_W bits) and then signals done. Unless paused, a compare
// checks whether the frame step saturates; if it does not, a second division over
// FSTEPS quotient bits yields it. Both divisions use the shared restoring divider. A
// finished result waits in the output register while the next sample is accepted.
// The hand-off stalls while an earlier result is still waiting. Configuration writes
// take effect at once; they are to be made while no sample is in flight, which the
// block does not enforce. The remainder of the millisecond division carries over to
// the next sample, so no tick is lost.
module tick_to_millisecond_timer #(
    parameter int COUNTER_BITS    = tmt_pkg::TMT_COUNTER_BITS,
    parameter int CLOCK_BITS      = tmt_pkg::TMT_CLOCK_BITS,
    parameter int SCALE_FRAC_BITS = tmt_pkg::TMT_SCALE_FRAC_BITS
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    // input stream
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    input  logic [tmt_pkg::TMT_IN_W-1:0]                      s_tdata,  // counter_value
    input  logic [tmt_pkg::TMT_USER_W-1:0]                    s_tuser,  // user_pause, code_pause
    // result stream
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // time_ms, time_ms_unclipped, time_ms_pause_mode, frame_step, ms_advanced
    output logic [tmt_pkg::TMT_OUT_NUM*tmt_pkg::TMT_OUT_W-1:0] m_tdata,
    // configuration write port
    input  logic                                              cfg_we,
    input  logic [tmt_pkg::TMT_CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [tmt_pkg::TMT_CFG_W-1:0]                     cfg_wdata
);

    import tmt_pkg::*;

    localparam int FACT_W = (SCALE_FRAC_BITS + 1 > TMT_SCALE_W) ?
                            SCALE_FRAC_BITS + 1 : TMT_SCALE_W;
    localparam int PROD_W = COUNTER_BITS + FACT_W;
    localparam int LEFT_W = TMT_TPM_W + SCALE_FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > LEFT_W) ? PROD_W : LEFT_W) + 1;
    localparam int DIV_W  = TMT_TPM_W + 5 + SCALE_FRAC_BITS;
    localparam int CMP_W  = (PROD_W > DIV_W + TMT_STEP_FRAC) ? PROD_W : DIV_W + TMT_STEP_FRAC;
    localparam int QX_A   = (SUM_W > CLOCK_BITS) ? SUM_W : CLOCK_BITS;
    localparam int QX_W   = (QX_A > TMT_OUT_W + 1) ? QX_A : TMT_OUT_W + 1;
    localparam int OCLK_W = (CLOCK_BITS > TMT_OUT_W) ? CLOCK_BITS : TMT_OUT_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int BIT_W  = $clog2(FACT_W);
    localparam int FSTEPS = 2 * TMT_STEP_FRAC;

    // Sequencer and state
    tmt_state_t state_reg, state_next;

    logic [TMT_SCALE_W-1:0]  scale_reg;
    logic [TMT_TPM_W-1:0]    tpm_reg;
    logic                    swp_reg;

    logic [COUNTER_BITS-1:0] last_reg, last_next;
    logic [LEFT_W-1:0]       left_reg, left_next;
    logic [CLOCK_BITS-1:0]   game_reg, game_next;
    logic [CLOCK_BITS-1:0]   uncl_reg, uncl_next;
    logic [CLOCK_BITS-1:0]   pclk_reg, pclk_next;

    logic [COUNTER_BITS-1:0] diff_reg, diff_next;
    logic [FACT_W-1:0]       factor_reg, factor_next;
    logic                    paused_reg, paused_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [SUM_W-1:0]        qms_reg, qms_next;
    logic [TMT_OUT_W-1:0]    step_reg, step_next;

    logic                    m_valid_reg, m_valid_next;
    logic [TMT_OUT_NUM*TMT_OUT_W-1:0] m_data_reg, m_data_next;

    // Divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_init;
    logic [SUM_W-1:0] div_dvd;
    logic [DIV_W-1:0] div_dsr;
    logic [CNT_W-1:0] div_steps;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    // Derived values
    logic                    in_paused;
    logic [COUNTER_BITS-1:0] in_now;
    logic [TMT_TPM_W-1:0]    tpm_eff;
    logic [TMT_TPM_W+4:0]    tpm20;
    logic [DIV_W-1:0]        ms_div;
    logic [DIV_W-1:0]        frame_div;
    logic [CMP_W-1:0]        prod_cmp;
    logic [CMP_W-1:0]        frame_lim;
    logic                    frame_sat;
    logic [QX_W-1:0]         qx;
    logic [CLOCK_BITS-1:0]   q_clk;
    logic [TMT_OUT_W-1:0]    ms_sat;
    logic [OCLK_W-1:0]       game_o, uncl_o, pclk_o;
    logic                    out_free;

    assign in_now    = s_tdata[COUNTER_BITS-1:0];
    assign in_paused = s_tuser[0] | s_tuser[1];
    assign tpm_eff   = (tpm_reg == '0) ? TMT_TPM_W'(1) : tpm_reg;
    assign tpm20     = (TMT_TPM_W + 5)'(tpm_eff) * (TMT_TPM_W + 5)'(TMT_FRAME_DIV);
    assign ms_div    = {5'b0, tpm_eff, {SCALE_FRAC_BITS{1'b0}}};
    assign frame_div = {tpm20, {SCALE_FRAC_BITS{1'b0}}};

    // Frame quotient overflows 32 bits exactly when product >= divisor * 2^16
    assign prod_cmp  = CMP_W'(prod_reg);
    assign frame_lim = CMP_W'(frame_div) << TMT_STEP_FRAC;
    assign frame_sat = (prod_cmp >= frame_lim);

    // Whole milliseconds, wrapped for the clocks and saturated for the report
    assign qx     = QX_W'(qms_reg);
    assign q_clk  = qx[CLOCK_BITS-1:0];
    assign ms_sat = (|qx[QX_W-1:TMT_OUT_W]) ? '1 : qx[TMT_OUT_W-1:0];

    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MUL;
            ST_MUL:       if (bit_reg == '0) state_next = ST_SUM;
            ST_SUM:       state_next = ST_DIV_MS;
            ST_DIV_MS:    if (div_done) state_next = paused_reg ? ST_DONE : ST_FRAME_CHK;
            ST_FRAME_CHK: state_next = frame_sat ? ST_DONE : ST_DIV_FRAME;
            ST_DIV_FRAME: if (div_done) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic
    always_comb begin
        last_next    = last_reg;
        left_next    = left_reg;
        game_next    = game_reg;
        uncl_next    = uncl_reg;
        pclk_next    = pclk_reg;
        diff_next    = diff_reg;
        factor_next  = factor_reg;
        paused_next  = paused_reg;
        prod_next    = prod_reg;
        bit_next     = bit_reg;
        qms_next     = qms_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_init     = '0;
        div_dvd      = SUM_W'(prod_reg) + SUM_W'(left_reg);
        div_dsr      = ms_div;
        div_steps    = CNT_W'(SUM_W);
        game_o       = OCLK_W'(game_reg);
        uncl_o       = OCLK_W'(uncl_reg);
        pclk_o       = OCLK_W'(pclk_reg);

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    diff_next   = in_now - last_reg;
                    last_next   = in_now;
                    paused_next = in_paused;
                    factor_next = (!in_paused || swp_reg) ? FACT_W'(scale_reg) :
                                  FACT_W'(1) << SCALE_FRAC_BITS;
                    prod_next   = '0;
                    bit_next    = BIT_W'(FACT_W - 1);
                end
            end
            ST_MUL: begin
                // MSB-first shift and add over the scale factor
                prod_next = {prod_reg[PROD_W-2:0], 1'b0} +
                            (factor_reg[bit_reg] ? PROD_W'(diff_reg) : '0);
                bit_next  = bit_reg - 1'b1;
            end
            ST_SUM: begin
                // Scaled ticks plus carried leftover over ticks_per_ms in scale units
                div_start = 1'b1;
            end
            ST_DIV_MS: begin
                if (div_done) begin
                    qms_next  = div_quo;
                    left_next = div_rem[LEFT_W-1:0];
                    step_next = '0;
                end
            end
            ST_FRAME_CHK: begin
                if (frame_sat) begin
                    step_next = '1;
                end else begin
                    div_start = 1'b1;
                    div_init  = DIV_W'(prod_cmp >> TMT_STEP_FRAC);
                    div_dvd   = {prod_reg[TMT_STEP_FRAC-1:0], {TMT_STEP_FRAC{1'b0}},
                                 {(SUM_W - FSTEPS){1'b0}}};
                    div_dsr   = frame_div;
                    div_steps = CNT_W'(FSTEPS);
                end
            end
            ST_DIV_FRAME: begin
                if (div_done) step_next = div_quo[TMT_OUT_W-1:0];
            end
            ST_DONE: begin
                if (out_free) begin
                    pclk_next = pclk_reg + q_clk;
                    if (!paused_reg) begin
                        game_next = game_reg + q_clk;
                        uncl_next = uncl_reg + q_clk;
                    end
                    game_o       = OCLK_W'(game_next);
                    uncl_o       = OCLK_W'(uncl_next);
                    pclk_o       = OCLK_W'(pclk_next);
                    m_valid_next = 1'b1;
                    m_data_next  = {ms_sat, step_reg, pclk_o[TMT_OUT_W-1:0],
                                    uncl_o[TMT_OUT_W-1:0], game_o[TMT_OUT_W-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= RST_TIME_SCALE;
            tpm_reg   <= RST_TICKS_PER_MS;
            swp_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TIME_SCALE:   scale_reg <= cfg_wdata[TMT_SCALE_W-1:0];
                REG_TICKS_PER_MS: tpm_reg   <= cfg_wdata[TMT_TPM_W-1:0];
                REG_SCALE_PAUSED: swp_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= '0;
            left_reg    <= '0;
            game_reg    <= '0;
            uncl_reg    <= '0;
            pclk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            left_reg    <= left_next;
            game_reg    <= game_next;
            uncl_reg    <= uncl_next;
            pclk_reg    <= pclk_next;
            m_valid_reg <= m_valid_next;
        end
        diff_reg   <= diff_next;
        factor_reg <= factor_next;
        paused_reg <= paused_next;
        prod_reg   <= prod_next;
        bit_reg    <= bit_next;
        qms_reg    <= qms_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    tmt_divider #(
        .DIV_W (DIV_W),
        .DVD_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .init_rem  (div_init),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[src/tmt_divider.sv]
// Iterative restoring divider, one quotient bit per cycle, shared by both divisions.
module tmt_divider #(
    parameter int DIV_W = 49,
    parameter int DVD_W = 81,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] init_rem,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] trial_sub;
    logic           trial_ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge  = (trial >= {1'b0, dsr_reg});
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = init_rem;
            dvd_next  = dividend;
            quo_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], trial_ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[src/tmt_checker.sv]
// Port-level checks for the tick-to-millisecond timer, bound to the top level.
module tmt_checker (
    input logic                                              aclk,
    input logic                                              aresetn,
    input logic                                              s_tvalid,
    input logic                                              s_tready,
    input logic                                              m_tvalid,
    input logic                                              m_tready,
    input logic [tmt_pkg::TMT_OUT_NUM*tmt_pkg::TMT_OUT_W-1:0] m_tdata
);

    import tmt_pkg::*;

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One sample at a time: busy right after a transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while a sample is in flight");

    // A result never appears in the cycle after an input transfer
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Game clock and unclipped clock advance together
    a_clocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TMT_OUT_W-1:0] == m_tdata[2*TMT_OUT_W-1:TMT_OUT_W]))
        else $error("game and unclipped clocks differ");

    // Reset clears the result channel
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tick_to_millisecond_timer tmt_checker u_tmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tmt_result_checker.sv]
// Result checker for the tick-to-millisecond timer: tracks the timer state and compares results.
module tmt_result_checker
    import tmt_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [TMT_IN_W-1:0]             s_tdata,
    input  logic [TMT_USER_W-1:0]           s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [TMT_OUT_NUM*TMT_OUT_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [TMT_CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [TMT_CFG_W-1:0]            cfg_wdata,
    input  logic                            end_check,
    output int                              mismatch_count,
    output int                              outstanding
);

    // Same layout as m_tdata: time_ms in the lowest bits
    typedef struct packed {
        logic [31:0] ms_advanced;
        logic [31:0] frame_step;
        logic [31:0] pause_ms;
        logic [31:0] unclipped_ms;
        logic [31:0] game_ms;
    } timer_reading_t;

    // Register copies
    logic [TMT_SCALE_W-1:0] scale_q12;
    logic [TMT_TPM_W-1:0]   ticks_per_ms;
    logic                   scale_always;

    // Timer state copies
    logic [63:0] prev_counter;
    logic [47:0] carry_ticks;
    logic [31:0] game_clock, free_clock, pause_clock;

    timer_reading_t pending_readings[$];
    logic           end_done = 1'b0;

    initial mismatch_count = 0;

    task automatic report(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
        if (mismatch_count < 40)
            $display("%0t tmt check: %s got %h want %h", $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    // Advance the timer by one counter sample and return the reading it yields
    function automatic timer_reading_t advance_timer(input logic [63:0] sample,
                                                     input logic [1:0]  flags);
        logic [63:0]    diff;
        logic [15:0]    factor;
        logic [31:0]    tpm;
        logic [127:0]   product, total, divisor, whole_ms, step;
        logic           paused;
        timer_reading_t r;

        paused       = |flags;
        diff         = sample - prev_counter;
        prev_counter = sample;
        factor       = (!paused || scale_always) ? scale_q12 : 16'(1 << TMT_SCALE_FRAC_BITS);
        tpm          = (ticks_per_ms == '0) ? 32'd1 : ticks_per_ms;

        // scaled ticks plus the carried remainder, over one millisecond in scaled ticks
        product     = 128'(diff) * 128'(factor);
        total       = product + 128'(carry_ticks);
        divisor     = 128'(tpm) << TMT_SCALE_FRAC_BITS;
        whole_ms    = total / divisor;
        carry_ticks = 48'(total % divisor);

        pause_clock = pause_clock + whole_ms[31:0];
        r.frame_step = '0;
        if (!paused) begin
            game_clock = game_clock + whole_ms[31:0];
            free_clock = free_clock + whole_ms[31:0];
            // truncated Q16.16 step from this sample alone
            step = (product << TMT_STEP_FRAC) /
                   ((128'(tpm) * TMT_FRAME_DIV) << TMT_SCALE_FRAC_BITS);
            r.frame_step = (step > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : step[31:0];
        end
        r.ms_advanced  = (whole_ms > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : whole_ms[31:0];
        r.game_ms      = game_clock;
        r.unclipped_ms = free_clock;
        r.pause_ms     = pause_clock;
        return r;
    endfunction

    // Watch both channels and the register port
    always @(posedge aclk) begin : watch
        timer_reading_t got, want;
        if (!aresetn) begin
            scale_q12    = RST_TIME_SCALE;
            ticks_per_ms = RST_TICKS_PER_MS;
            scale_always = 1'b0;
            prev_counter = '0;
            carry_ticks  = '0;
            game_clock   = '0;
            free_clock   = '0;
            pause_clock  = '0;
            pending_readings.delete();
        end else begin
            // result transfer: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_readings.size() == 0) begin
                    report("result with none pending, time_ms", got.game_ms, '0);
                end else begin
                    want = pending_readings.pop_front();
                    if (got.game_ms !== want.game_ms)
                        report("time_ms", got.game_ms, want.game_ms);
                    if (got.unclipped_ms !== want.unclipped_ms)
                        report("time_ms_unclipped", got.unclipped_ms, want.unclipped_ms);
                    if (got.pause_ms !== want.pause_ms)
                        report("time_ms_pause_mode", got.pause_ms, want.pause_ms);
                    if (got.frame_step !== want.frame_step)
                        report("frame_step", got.frame_step, want.frame_step);
                    if (got.ms_advanced !== want.ms_advanced)
                        report("ms_advanced", got.ms_advanced, want.ms_advanced);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TIME_SCALE:   scale_q12    = cfg_wdata[TMT_SCALE_W-1:0];
                    REG_TICKS_PER_MS: ticks_per_ms = cfg_wdata[TMT_TPM_W-1:0];
                    REG_SCALE_PAUSED: scale_always = cfg_wdata[0];
                    default: ;
                endcase
            end
            // sample transfer: predict its reading
            if (s_tvalid && s_tready)
                pending_readings.push_back(advance_timer(s_tdata, s_tuser));
            // predictions never answered
            if (end_check && !end_done) begin
                foreach (pending_readings[i])
                    report("missing result, time_ms", 'x, pending_readings[i].game_ms);
                end_done = 1'b1;
            end
        end
        outstanding <= pending_readings.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the tick-to-millisecond timer: stimulus, flow control and verdict.
module tb_top;
    import tmt_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [TMT_IN_W-1:0]              s_tdata;   // counter_value
    logic [TMT_USER_W-1:0]            s_tuser;   // user_pause, code_pause
    logic                             m_tvalid;
    logic                             m_tready;
    // time_ms, time_ms_unclipped, time_ms_pause_mode, frame_step, ms_advanced
    logic [TMT_OUT_NUM*TMT_OUT_W-1:0] m_tdata;
    logic                             cfg_we;
    logic [TMT_CFG_ADDR_W-1:0]        cfg_addr;
    logic [TMT_CFG_W-1:0]             cfg_wdata;
    logic                             end_check;

    int          mismatch_count;
    int          outstanding;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;
    logic [63:0] tick_now = '0;
    logic [31:0] cur_tpm = RST_TICKS_PER_MS;

    tick_to_millisecond_timer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    tmt_result_checker result_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .end_check      (end_check),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[tick_to_millisecond_timer] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 6);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Offer one counter sample and wait for its transfer
    task automatic send_sample(input logic [63:0] sample, input logic [1:0] flags);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= flags;
        tick_now = sample;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write all three registers while the timer is idle
    task automatic set_config(input logic [15:0] scale, input logic [31:0] tpm, input logic swp);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TIME_SCALE;
        cfg_wdata <= 32'(scale);
        @(posedge aclk);
        cfg_addr  <= REG_TICKS_PER_MS;
        cfg_wdata <= tpm;
        @(posedge aclk);
        cfg_addr  <= REG_SCALE_PAUSED;
        cfg_wdata <= 32'(swp);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_tpm = tpm;
    endtask

    // Next counter sample: mostly frame-sized steps, some tiny, huge, backward or arbitrary
    function automatic logic [63:0] next_sample(input logic [63:0] cur, input logic [31:0] tpm);
        logic [63:0] unit;
        int          pick;
        unit = (tpm == '0) ? 64'd1 : 64'(tpm);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return cur + ((64'($urandom_range(0, 4000)) * unit) >> 8);
        if (pick < 75)
            return cur + 64'($urandom_range(0, 50));
        if (pick < 88)
            return cur + ({$urandom, $urandom} >> $urandom_range(0, 63));
        if (pick < 95)
            return cur - 64'($urandom_range(1, 1000));
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        logic [1:0] flags;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_TIME_SCALE;
        cfg_wdata = '0;
        end_check = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero step, exact millisecond, remainder carry, pause flags
        send_sample(64'd0, 2'b00);
        send_sample(64'd10000, 2'b00);
        send_sample(64'd15000, 2'b00);
        send_sample(64'd25000, 2'b00);
        send_sample(64'd45000, 2'b01);
        send_sample(64'd65000, 2'b10);
        send_sample(64'd85000, 2'b11);
        // counter going backwards: near-full wrap, saturating outputs, wrapping clocks
        send_sample(64'd84999, 2'b00);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 2'b00);
        send_sample(64'd0, 2'b00);
        send_sample(64'h5555_5555_5555_5555, 2'b00);
        send_sample(64'hAAAA_AAAA_AAAA_AAAA, 2'b01);
        // zero divisor, top scale, scaling while paused
        set_config(16'hFFFF, 32'd0, 1'b1);
        send_sample(tick_now + 64'd1000, 2'b00);
        send_sample(tick_now + 64'd1000, 2'b10);
        send_sample(tick_now + 64'd65536, 2'b01);
        // zero scale with the largest divisor; paused runs at real time
        set_config(16'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(tick_now + 64'h100_0000_0000, 2'b00);
        send_sample(tick_now + 64'h2000_0000_0000, 2'b11);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 2'b01);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_config(16'd4096, 32'd10000, 1'b0);
                1: set_config(16'hFFFF, 32'd1, 1'b1);
                2: set_config(16'd0, 32'hFFFF_FFFF, 1'b0);
                3: set_config(16'($urandom), 32'($urandom_range(1, 100000)), 1'b1);
                4: set_config(16'd2048, 32'd0, 1'b0);
                5: set_config(16'($urandom), $urandom, 1'($urandom));
                6: set_config(16'd8192, 32'd3579, 1'b1);
                default: set_config(16'($urandom), 32'($urandom_range(1, 1000)), 1'b0);
            endcase
            no_idle = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((phase == 0 || phase == 5) && n == 30)
                    hold_request = 1'b1;
                if (phase == 3 && n == 75)
                    drain();
                flags = ($urandom_range(0, 99) < 65) ? 2'b00 : 2'($urandom_range(1, 3));
                send_sample(next_sample(tick_now, cur_tpm), flags);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (300) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[tick_to_millisecond_timer] OK");
        else
            $display("[tick_to_millisecond_timer] ERROR");
        $finish;
    end

endmodule
